// ===== rtl/core/pixel_graph_neighbour_mask_macros.svh =====
// Assertion macros used by the pixel graph neighbour mask top level
`ifndef PIXEL_GRAPH_NEIGHBOUR_MASK_MACROS_SVH
`define PIXEL_GRAPH_NEIGHBOUR_MASK_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low
`define PGNM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgnm assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define PGNM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgnm assertion failed");
`else
`define PGNM_ASSERT_IMP(label, ante, cons)
`define PGNM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/pgnm_pkg.sv =====
// Shared constants and types of the pixel graph neighbour mask block
`timescale 1ns / 1ps

package pgnm_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = COL_W + 1;
    localparam int HEIGHT_W = ROW_W + 1;
    localparam int NODE_W   = COL_W + ROW_W;
    localparam int PIX_W    = 8;
    localparam int MASK_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_W;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [PIX_W-1:0]    THRESHOLD_RESET = 8'd100;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = HEIGHT_W'(480);

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // Classified item handed from the front to the window stage
    typedef struct packed {
        logic [COL_W-1:0]  addr;
        logic              node_bit;
        logic              has_result;
        logic              frame_end;
        logic              left_ok;
        logic              right_ok;
        logic              up_ok;
        logic              down_ok;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [NODE_W-1:0] node_id;
    } pgnm_item_t;

    // One result transaction
    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              is_node;
        logic [MASK_W-1:0] neighbour_mask;
        logic              frame_end;
    } pgnm_result_t;

endpackage

// ===== rtl/core/pgnm_front.sv =====
// Front end: configuration registers, raster counters and item classification
`timescale 1ns / 1ps

module pgnm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic                                func,
    input  logic [pgnm_pkg::PIX_W-1:0]          pixel,
    input  logic                                cfg_write,
    input  logic [pgnm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pgnm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                item_valid,
    output pgnm_pkg::pgnm_item_t                item
);

    localparam int COL_W    = pgnm_pkg::COL_W;
    localparam int ROW_W    = pgnm_pkg::ROW_W;
    localparam int WIDTH_W  = pgnm_pkg::WIDTH_W;
    localparam int HEIGHT_W = pgnm_pkg::HEIGHT_W;
    localparam int NODE_W   = pgnm_pkg::NODE_W;
    localparam int PIX_W    = pgnm_pkg::PIX_W;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        if (v == '0)
            r = WIDTH_W'(1);
        else if (v > WIDTH_W'(pgnm_pkg::MAX_WIDTH))
            r = WIDTH_W'(pgnm_pkg::MAX_WIDTH);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
        logic [HEIGHT_W-1:0] r;
        if (v == '0)
            r = HEIGHT_W'(1);
        else if (v > HEIGHT_W'(pgnm_pkg::MAX_HEIGHT))
            r = HEIGHT_W'(pgnm_pkg::MAX_HEIGHT);
        else
            r = v;
        return r;
    endfunction

    logic [PIX_W-1:0]    threshold_reg, threshold_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [HEIGHT_W-1:0] in_row_reg, in_row_next;
    logic [NODE_W-1:0]   node_cnt_reg, node_cnt_next;

    logic                flush;
    logic                col_zero;
    logic                ready;
    logic                take;
    logic                node_bit;
    logic                last;
    logic [WIDTH_W-1:0]  width_m1;
    logic [HEIGHT_W-1:0] height_m1;
    logic [COL_W-1:0]    cc;
    logic [HEIGHT_W-1:0] row_back;
    logic [ROW_W-1:0]    rc;
    logic [WIDTH_W-1:0]  col_inc;

    // Classify the item at the input against the current raster position
    always_comb
    begin
        flush     = in_row_reg >= height_reg;
        col_zero  = (in_col_reg == '0);
        ready     = (in_row_reg >= HEIGHT_W'(2)) || ((in_row_reg == HEIGHT_W'(1)) && !col_zero);
        width_m1  = width_reg - WIDTH_W'(1);
        height_m1 = height_reg - HEIGHT_W'(1);
        // the window centre trails the input by one row and one column
        cc        = col_zero ? width_m1[COL_W-1:0] : in_col_reg - COL_W'(1);
        row_back  = col_zero ? in_row_reg - HEIGHT_W'(2) : in_row_reg - HEIGHT_W'(1);
        rc        = row_back[ROW_W-1:0];
        last      = ready && ({1'b0, cc} == width_m1) && ({1'b0, rc} == height_m1);
        node_bit  = !flush && (pixel > threshold_reg);
        // a flush tick inside the frame is dropped without side effects
        take      = push && !full && (flush || !func);
        col_inc   = {1'b0, in_col_reg} + WIDTH_W'(1);
    end

    // Hand the classified item to the window stage
    always_comb
    begin
        item_valid      = take;
        item.addr       = in_col_reg;
        item.node_bit   = node_bit;
        item.has_result = ready;
        item.frame_end  = last;
        item.left_ok    = (cc != '0);
        item.right_ok   = ({1'b0, cc} != width_m1);
        item.up_ok      = (rc != '0);
        item.down_ok    = ({1'b0, rc} != height_m1);
        item.col        = cc;
        item.row        = rc;
        item.node_id    = node_cnt_reg;
    end

    // Register writes and raster advance
    always_comb
    begin
        threshold_next = threshold_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        node_cnt_next  = node_cnt_reg;
        if (cfg_write)
        begin
            case (cfg_addr)
                pgnm_pkg::REG_THRESHOLD:
                begin
                    threshold_next = cfg_data[PIX_W-1:0];
                end
                pgnm_pkg::REG_FRAME_WIDTH:
                begin
                    width_next    = clamp_width(cfg_data[WIDTH_W-1:0]);
                    in_col_next   = '0;
                    in_row_next   = '0;
                    node_cnt_next = '0;
                end
                pgnm_pkg::REG_FRAME_HEIGHT:
                begin
                    height_next   = clamp_height(cfg_data[HEIGHT_W-1:0]);
                    in_col_next   = '0;
                    in_row_next   = '0;
                    node_cnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (take)
        begin
            if (last)
            begin
                // restart the frame after its final result
                in_col_next   = '0;
                in_row_next   = '0;
                node_cnt_next = '0;
            end
            else
            begin
                if (col_inc >= width_reg)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + HEIGHT_W'(1);
                end
                else
                begin
                    in_col_next = col_inc[COL_W-1:0];
                end
                if (ready)
                    node_cnt_next = node_cnt_reg + NODE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= pgnm_pkg::THRESHOLD_RESET;
            width_reg     <= pgnm_pkg::WIDTH_RESET;
            height_reg    <= pgnm_pkg::HEIGHT_RESET;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            node_cnt_reg  <= '0;
        end
        else
        begin
            threshold_reg <= threshold_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            node_cnt_reg  <= node_cnt_next;
        end
    end

endmodule

// ===== rtl/core/pgnm_window.sv =====
// Back end: two one-bit line stores, 3x3 window and neighbour mask
`timescale 1ns / 1ps

module pgnm_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  pgnm_pkg::pgnm_item_t      in_item,
    output logic                      stage_valid,
    output logic                      res_valid,
    output pgnm_pkg::pgnm_result_t    res
);

    localparam int COL_W = pgnm_pkg::COL_W;

    // Mask bit positions
    localparam int MASK_UL = 0;
    localparam int MASK_U  = 1;
    localparam int MASK_UR = 2;
    localparam int MASK_L  = 3;
    localparam int MASK_R  = 4;
    localparam int MASK_DL = 5;
    localparam int MASK_D  = 6;
    localparam int MASK_DR = 7;

    // Line stores; stale contents only ever land on masked window cells
    logic upper_mem  [pgnm_pkg::MAX_WIDTH];
    logic middle_mem [pgnm_pkg::MAX_WIDTH];

    logic                 up_rd_reg;
    logic                 mid_rd_reg;
    logic                 stage_valid_reg, stage_valid_next;
    pgnm_pkg::pgnm_item_t stage_item_reg, stage_item_next;
    logic                 fwd_reg, fwd_next;
    logic                 fwd_up_reg, fwd_up_next;
    logic                 fwd_mid_reg, fwd_mid_next;
    logic [8:0]           window_reg, window_next;

    logic                 up_eff;
    logic                 mid_eff;
    logic                 left_ok;
    logic                 right_ok;
    logic                 up_ok;
    logic                 down_ok;
    logic [COL_W-1:0]     wr_addr;

    // Read on accept, write back when the stage retires
    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            upper_mem[wr_addr]  <= mid_eff;
            middle_mem[wr_addr] <= stage_item_reg.node_bit;
        end
        if (in_valid)
        begin
            up_rd_reg  <= upper_mem[in_item.addr];
            mid_rd_reg <= middle_mem[in_item.addr];
        end
    end

    // Shift the window and form the mask
    always_comb
    begin
        wr_addr  = stage_item_reg.addr;
        // bypass the write in flight when two items hit the same column back to back
        up_eff   = fwd_reg ? fwd_up_reg : up_rd_reg;
        mid_eff  = fwd_reg ? fwd_mid_reg : mid_rd_reg;
        left_ok  = stage_item_reg.left_ok;
        right_ok = stage_item_reg.right_ok;
        up_ok    = stage_item_reg.up_ok;
        down_ok  = stage_item_reg.down_ok;

        window_next = window_reg;
        if (stage_valid_reg)
            window_next = {stage_item_reg.node_bit, mid_eff, up_eff, window_reg[8:3]};

        res.node_id                 = stage_item_reg.node_id;
        res.col                     = stage_item_reg.col;
        res.row                     = stage_item_reg.row;
        res.is_node                 = window_next[4];
        res.frame_end               = stage_item_reg.frame_end;
        res.neighbour_mask[MASK_UL] = window_next[0] && left_ok && up_ok;
        res.neighbour_mask[MASK_U]  = window_next[3] && up_ok;
        res.neighbour_mask[MASK_UR] = window_next[6] && right_ok && up_ok;
        res.neighbour_mask[MASK_L]  = window_next[1] && left_ok;
        res.neighbour_mask[MASK_R]  = window_next[7] && right_ok;
        res.neighbour_mask[MASK_DL] = window_next[2] && left_ok && down_ok;
        res.neighbour_mask[MASK_D]  = window_next[5] && down_ok;
        res.neighbour_mask[MASK_DR] = window_next[8] && right_ok && down_ok;

        res_valid   = stage_valid_reg && stage_item_reg.has_result;
        stage_valid = stage_valid_reg;
    end

    // Advance the stage and capture bypass data
    always_comb
    begin
        stage_valid_next = in_valid;
        stage_item_next  = in_valid ? in_item : stage_item_reg;
        fwd_next         = in_valid && stage_valid_reg && (in_item.addr == stage_item_reg.addr);
        fwd_up_next      = mid_eff;
        fwd_mid_next     = stage_item_reg.node_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            fwd_reg         <= 1'b0;
            window_reg      <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            fwd_reg         <= fwd_next;
            window_reg      <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
        fwd_up_reg     <= fwd_up_next;
        fwd_mid_reg    <= fwd_mid_next;
    end

endmodule

// ===== rtl/core/pgnm_result_fifo.sv =====
// Short result queue between the window stage and the result ports
`timescale 1ns / 1ps

module pgnm_result_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  pgnm_pkg::pgnm_result_t        wr_data,
    input  logic                          rd_en,
    output pgnm_pkg::pgnm_result_t        rd_data,
    output logic                          empty,
    output logic [pgnm_pkg::RQ_AW:0]      count
);

    localparam int AW = pgnm_pkg::RQ_AW;

    pgnm_pkg::pgnm_result_t entries_reg [pgnm_pkg::RQ_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + (AW+1)'(1);
        else if (!wr_en && rd_en)
            count_next = count_reg - (AW+1)'(1);
        rd_data = entries_reg[rd_ptr_reg];
        empty   = (count_reg == '0);
        count   = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/core/pixel_graph_neighbour_mask.sv =====
// Top level of the pixel graph neighbour mask block
//
//   channel   direction  handshake            payload
//   input     in         push / full          func, pixel
//   result    out        empty / pop          node_id, col, row, is_node,
//                                             neighbour_mask, frame_end
//   config    in         cfg_write            cfg_addr, cfg_data
//
// One input transaction per cycle is sustained while full is low; a line store
// read/modify/write is bypassed when back-to-back items share a column, e.g. one-column frames.
// A result is written to the 4-entry queue at the edge after its completing input is
// accepted and, into an empty queue, is on the result ports right after that edge; the first
// frame needs frame_width + 2 input transactions, frame_width + 1 flush ticks drain the end.
// Reset clears control state only; full rises when queue plus window stage reach four.
`timescale 1ns / 1ps
`include "pixel_graph_neighbour_mask_macros.svh"

module pixel_graph_neighbour_mask (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                func,
    input  logic [pgnm_pkg::PIX_W-1:0]          pixel,
    output logic                                empty,
    input  logic                                pop,
    output logic [pgnm_pkg::NODE_W-1:0]         node_id,
    output logic [pgnm_pkg::COL_W-1:0]          col,
    output logic [pgnm_pkg::ROW_W-1:0]          row,
    output logic                                is_node,
    output logic [pgnm_pkg::MASK_W-1:0]         neighbour_mask,
    output logic                                frame_end,
    input  logic                                cfg_write,
    input  logic [pgnm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pgnm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = pgnm_pkg::RQ_AW;

    logic                   item_valid;
    pgnm_pkg::pgnm_item_t   item;
    logic                   stage_valid;
    logic                   res_valid;
    pgnm_pkg::pgnm_result_t res;
    pgnm_pkg::pgnm_result_t head;
    logic [AW:0]            rq_count;
    logic [AW+1:0]          occupancy;
    logic                   rq_pop;

    // Hold off input while queued and in-flight results could fill the queue
    always_comb
    begin
        occupancy = {1'b0, rq_count} + {{(AW+1){1'b0}}, stage_valid};
        full      = occupancy >= (AW+2)'(pgnm_pkg::RQ_DEPTH);
        rq_pop    = pop && !empty;
    end

    pgnm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .pixel      (pixel),
        .cfg_write  (cfg_write),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item)
    );

    pgnm_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (item_valid),
        .in_item     (item),
        .stage_valid (stage_valid),
        .res_valid   (res_valid),
        .res         (res)
    );

    pgnm_result_fifo u_result_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (rq_pop),
        .rd_data (head),
        .empty   (empty),
        .count   (rq_count)
    );

    // Drive the result ports from the queue head
    always_comb
    begin
        node_id        = head.node_id;
        col            = head.col;
        row            = head.row;
        is_node        = head.is_node;
        neighbour_mask = head.neighbour_mask;
        frame_end      = head.frame_end;
    end

    // Never push into a full queue
    `PGNM_ASSERT_IMP(a_no_queue_overflow, res_valid, rq_count != (AW+1)'(pgnm_pkg::RQ_DEPTH))
    // The first node id of a frame belongs to the top-left pixel
    `PGNM_ASSERT_IMP(a_first_node_origin, res_valid && (res.node_id == '0), (res.col == '0) && (res.row == '0))
    // Popping the only entry without a refill leaves the queue empty
    `PGNM_ASSERT_NXT(a_drain_to_empty, rq_pop && !res_valid && (rq_count == (AW+1)'(1)), empty)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the pixel graph neighbour mask block
`timescale 1ns / 1ps

module tb_top;

    localparam int CFG_IDX_W  = pgnm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pgnm_pkg::CFG_DATA_W;
    localparam int PIX_W      = pgnm_pkg::PIX_W;
    localparam int NODE_W     = pgnm_pkg::NODE_W;
    localparam int COL_W      = pgnm_pkg::COL_W;
    localparam int ROW_W      = pgnm_pkg::ROW_W;
    localparam int MASK_W     = pgnm_pkg::MASK_W;
    localparam int WIDTH_W    = pgnm_pkg::WIDTH_W;
    localparam int HEIGHT_W   = pgnm_pkg::HEIGHT_W;
    localparam int MAX_WIDTH  = pgnm_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = pgnm_pkg::MAX_HEIGHT;

    localparam logic                 FUNC_PIXEL    = 1'b0;
    localparam logic                 FUNC_FLUSH    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
    localparam int                   SETTLE_CYCLES = 12;
    localparam int                   RANDOM_ITEMS  = 150;

    typedef enum int {PM_MIXED, PM_BRIGHT, PM_DARK, PM_CHECKER} pixel_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    logic                  func      = 1'b0;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [NODE_W-1:0]     node_id;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic                  is_node;
    logic [MASK_W-1:0]     neighbour_mask;
    logic                  frame_end;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the block: line stores, window and raster position
    logic        node_row_upper [MAX_WIDTH];
    logic        node_row_middle[MAX_WIDTH];
    logic [8:0]  win_bits;
    int unsigned pos_col;
    int unsigned pos_row;
    int unsigned cur_threshold;
    int unsigned cur_width;
    int unsigned cur_height;

    pgnm_pkg::pgnm_result_t expected_windows[$];

    pixel_mode_t pixel_mode    = PM_MIXED;
    logic        frame_closed  = 1'b0;
    int          burst_left    = 0;
    int          items_counted = 0;
    int          ticks_ignored = 0;
    int          frames_closed = 0;
    int          results_seen  = 0;
    int          reg_writes    = 0;
    int          error_count   = 0;

    pixel_graph_neighbour_mask dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .func           (func),
        .pixel          (pixel),
        .empty          (empty),
        .pop            (pop),
        .node_id        (node_id),
        .col            (col),
        .row            (row),
        .is_node        (is_node),
        .neighbour_mask (neighbour_mask),
        .frame_end      (frame_end),
        .cfg_write      (cfg_write),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Return the raster position to the frame origin
    function automatic void restart_raster();
        pos_col = 0;
        pos_row = 0;
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            node_row_upper[i]  = 1'b0;
            node_row_middle[i] = 1'b0;
        end
        win_bits      = '0;
        cur_threshold = pgnm_pkg::THRESHOLD_RESET;
        cur_width     = pgnm_pkg::WIDTH_RESET;
        cur_height    = pgnm_pkg::HEIGHT_RESET;
        restart_raster();
    endfunction

    // Clamp a geometry register into 1..maxv
    function automatic int unsigned fit_dim(int unsigned v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        reg_writes++;
        case (idx)
            pgnm_pkg::REG_THRESHOLD:
                cur_threshold = data[PIX_W-1:0];
            pgnm_pkg::REG_FRAME_WIDTH:
            begin
                cur_width = fit_dim(data[WIDTH_W-1:0], MAX_WIDTH);
                restart_raster();
            end
            pgnm_pkg::REG_FRAME_HEIGHT:
            begin
                cur_height = fit_dim(data[HEIGHT_W-1:0], MAX_HEIGHT);
                restart_raster();
            end
            default:
                ;
        endcase
    endfunction

    function automatic logic in_frame();
        return (pos_row * cur_width + pos_col) < (cur_width * cur_height);
    endfunction

    // Shift one accepted transaction through the window and queue the result it completes
    function automatic void predict_window(logic f, logic [PIX_W-1:0] p);
        int unsigned            total;
        int unsigned            cc;
        int unsigned            rc;
        int unsigned            centre;
        int                     dc;
        int                     dr;
        logic                   draining;
        logic                   node_now;
        logic                   up_bit;
        logic                   mid_bit;
        logic                   ready;
        logic [7:0]             mask;
        pgnm_pkg::pgnm_result_t want;

        total    = cur_width * cur_height;
        draining = !in_frame();
        if (!draining && f == FUNC_FLUSH)
        begin
            ticks_ignored++;
            return;
        end
        items_counted++;

        node_now = !draining && (p > cur_threshold);
        up_bit   = node_row_upper[pos_col];
        mid_bit  = node_row_middle[pos_col];
        node_row_upper[pos_col]  = mid_bit;
        node_row_middle[pos_col] = node_now;
        win_bits = {node_now, mid_bit, up_bit, win_bits[8:3]};

        ready = (pos_row >= 2) || (pos_row == 1 && pos_col >= 1);
        if (pos_col == 0)
        begin
            cc = cur_width - 1;
            rc = pos_row - 2;
        end
        else
        begin
            cc = pos_col - 1;
            rc = pos_row - 1;
        end

        pos_col++;
        if (pos_col >= cur_width)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (!ready)
            return;

        // Neighbours in order UL, U, UR, L, R, DL, D, DR; drop those off the frame
        mask = '0;
        for (int i = 0; i < 8; i++)
        begin
            dc = (i == 0 || i == 3 || i == 5) ? -1 : ((i == 1 || i == 6) ? 0 : 1);
            dr = (i < 3) ? -1 : ((i < 5) ? 0 : 1);
            if (dc < 0 && cc == 0)
                continue;
            if (dc > 0 && cc + 1 >= cur_width)
                continue;
            if (dr < 0 && rc == 0)
                continue;
            if (dr > 0 && rc + 1 >= cur_height)
                continue;
            mask[i] = win_bits[(dc + 1) * 3 + (dr + 1)];
        end

        centre              = rc * cur_width + cc;
        want.node_id        = centre[NODE_W-1:0];
        want.col            = cc[COL_W-1:0];
        want.row            = rc[ROW_W-1:0];
        want.is_node        = win_bits[4];
        want.neighbour_mask = mask;
        want.frame_end      = (centre + 1 >= total);
        expected_windows    = {expected_windows, want};

        if (want.frame_end)
        begin
            restart_raster();
            frame_closed = 1'b1;
            frames_closed++;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int near;

        case (pixel_mode)
            PM_BRIGHT:
                return 8'd255;
            PM_DARK:
                return 8'd0;
            PM_CHECKER:
                return ((pos_row + pos_col) % 2) ? 8'd255 : 8'd0;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:
                        return 8'($urandom_range(0, 255));
                    1:
                    begin
                        near = int'(cur_threshold) + int'($urandom_range(0, 4)) - 2;
                        if (near < 0)
                            near = 0;
                        if (near > 255)
                            near = 255;
                        return near[PIX_W-1:0];
                    end
                    2:
                        return $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default:
                        return 8'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    // Send one input transaction, with bursts and random gaps in between
    task automatic send_item(input logic f, input logic [PIX_W-1:0] p);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        @(negedge clk);
        push  <= 1'b1;
        func  <= f;
        pixel <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_window(f, p);
    endtask

    // Hold the input low until every expected result is back and the pipe is empty
    task automatic settle_idle();
        @(negedge clk);
        push <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] data;

        data = CFG_DATA_W'(value);
        settle_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drive pixels, optional ignored ticks inside the frame, then drain items until frame end
    task automatic run_frame(input int noise_pct, input int stop_after);
        int sent;

        sent         = 0;
        frame_closed = 1'b0;
        while (!frame_closed && (stop_after < 0 || sent < stop_after))
        begin
            if (!in_frame())
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 99) < noise_pct)
                send_item(FUNC_FLUSH, 8'($urandom_range(0, 255)));
            else
                send_item(FUNC_PIXEL, pick_pixel());
            sent++;
        end
    endtask

    // Compare the popped result with the oldest expectation
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        pgnm_pkg::pgnm_result_t want;

        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (expected_windows.size() == 0)
            begin
                $display("%0t: result node_id %0d with nothing expected, expected none, actual 1",
                         $time, node_id);
                error_count++;
            end
            else
            begin
                want = expected_windows.pop_front();
                check_field("node_id", want.node_id, node_id);
                check_field("col", want.col, col);
                check_field("row", want.row, row);
                check_field("is_node", want.is_node, is_node);
                check_field("neighbour_mask", want.neighbour_mask, neighbour_mask);
                check_field("frame_end", want.frame_end, frame_end);
            end
        end
    end

    // Receiver: switch at random between always-ready, coin-flip, fixed-pattern and slow phases
    int         rx_mode    = 0;
    int         rx_left    = 0;
    int         rx_phase   = 0;
    logic [7:0] rx_pattern = 8'hff;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode    = $urandom_range(0, 3);
            rx_left    = $urandom_range(20, 300);
            rx_pattern = 8'($urandom_range(0, 255));
            rx_pattern[0] = 1'b1;
        end
        else
            rx_left--;
        rx_phase = (rx_phase + 1) % 8;
        case (rx_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= rx_pattern[rx_phase];
            default: pop <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Default registers: warm-up at 640 columns and the first few windows
    task automatic test_reset_defaults();
        logic [PIX_W-1:0] p;

        for (int i = 0; i < 645; i++)
        begin
            case (i)
                0:       p = 8'd0;
                1:       p = 8'd100;
                2:       p = 8'd101;
                3:       p = 8'd255;
                default: p = 8'($urandom_range(0, 255));
            endcase
            send_item(FUNC_PIXEL, p);
        end
    endtask

    // Tiny frames: all nodes, no nodes, single pixel, checkerboard
    task automatic test_small_frames();
        write_reg(pgnm_pkg::REG_THRESHOLD, 0);
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 3);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 3);
        pixel_mode = PM_BRIGHT;
        run_frame(0, -1);

        write_reg(pgnm_pkg::REG_THRESHOLD, 255);
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 2);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 2);
        run_frame(0, -1);

        write_reg(pgnm_pkg::REG_THRESHOLD, 128);
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 0);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 1);
        pixel_mode = PM_MIXED;
        run_frame(0, -1);

        write_reg(pgnm_pkg::REG_THRESHOLD, 127);
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 4);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 4);
        pixel_mode = PM_CHECKER;
        run_frame(0, -1);
        pixel_mode = PM_MIXED;
    endtask

    // Flush ticks inside the frame are dropped; pixels after the frame act as flush
    task automatic test_flush_and_drain();
        write_reg(pgnm_pkg::REG_THRESHOLD, 100);
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 4);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 3);
        run_frame(30, -1);
        pixel_mode = PM_DARK;
        run_frame(30, -1);
        pixel_mode = PM_MIXED;
    endtask

    // Threshold and unused-index writes mid-frame must not restart the raster
    task automatic test_threshold_midframe();
        write_reg(pgnm_pkg::REG_THRESHOLD, 50);
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 5);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 4);
        run_frame(0, 12);
        write_reg(pgnm_pkg::REG_THRESHOLD, 200);
        write_reg(REG_UNUSED, $urandom_range(0, 8191));
        run_frame(10, -1);
    endtask

    // Geometry writes mid-frame restart the raster
    task automatic test_restart_midframe();
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 6);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 5);
        run_frame(5, 20);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 3);
        run_frame(5, -1);
        run_frame(0, 9);
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 7);
        run_frame(5, -1);
    endtask

    // Clamped registers: widest single row into its first windows, then the tallest column
    task automatic test_geometry_extremes();
        write_reg(pgnm_pkg::REG_THRESHOLD, $urandom_range(0, 255));
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 13'h1fff);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 0);
        run_frame(0, MAX_WIDTH + 6);
        write_reg(pgnm_pkg::REG_FRAME_WIDTH, 0);
        write_reg(pgnm_pkg::REG_FRAME_HEIGHT, 13'h1fff);
        run_frame(2, 48);
    endtask

    // Random geometry and content, mostly whole frames, some cut short
    task automatic test_random_frames();
        int   start;
        int   w;
        int   h;
        int   pick;
        logic broke;

        start = items_counted;
        broke = 1'b1;
        w     = 1;
        h     = 1;
        while (items_counted - start < RANDOM_ITEMS)
        begin
            if (broke || $urandom_range(0, 9) < 4)
            begin
                pick = $urandom_range(0, 99);
                w = (pick < 65) ? $urandom_range(1, 8) :
                    (pick < 93) ? $urandom_range(9, 32) : $urandom_range(33, 120);
                pick = $urandom_range(0, 99);
                h = (pick < 70) ? $urandom_range(1, 6) :
                    (pick < 95) ? $urandom_range(7, 16) : $urandom_range(17, 40);
                while (w * h > 150)
                    h = h / 2;
                write_reg(pgnm_pkg::REG_FRAME_WIDTH, (w == 1 && $urandom_range(0, 1)) ? 0 : w);
                write_reg(pgnm_pkg::REG_FRAME_HEIGHT, h);
            end
            if ($urandom_range(0, 9) < 3)
            begin
                pick = $urandom_range(0, 9);
                write_reg(pgnm_pkg::REG_THRESHOLD,
                          (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255));
            end
            pick = $urandom_range(0, 19);
            pixel_mode = (pick == 0) ? PM_BRIGHT : (pick == 1) ? PM_DARK :
                         (pick == 2) ? PM_CHECKER : PM_MIXED;
            if ($urandom_range(0, 99) < 12)
            begin
                run_frame($urandom_range(0, 10), $urandom_range(1, w * h));
                broke = 1'b1;
            end
            else
            begin
                run_frame($urandom_range(0, 1) ? 0 : $urandom_range(2, 15), -1);
                broke = 1'b0;
            end
        end
        pixel_mode = PM_MIXED;
    endtask

    initial
    begin
        reset_shadow();
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_small_frames();
        test_flush_and_drain();
        test_threshold_midframe();
        test_restart_midframe();
        test_geometry_extremes();
        test_random_frames();
        settle_idle();

        $display("tb_top: %0d items shifted in, %0d in-frame flush ticks dropped, %0d results checked",
                 items_counted, ticks_ignored, results_seen);
        $display("tb_top: %0d frames closed over %0d register writes, clamped geometries included",
                 frames_closed, reg_writes);
        if (error_count == 0 && expected_windows.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pgnm_pkg.sv
rtl/core/pgnm_front.sv
rtl/core/pgnm_window.sv
rtl/core/pgnm_result_fifo.sv
rtl/core/pixel_graph_neighbour_mask.sv
verif/tb_top.sv
